// File: src/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared constants for the barometric pressure compensation block: register
// map of the configuration port and its index width.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_OVERSAMPLING = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AC1_AC2      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AC3_AC4      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AC5_AC6      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_B1_B2        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MC_MD        = 3'd5;

    localparam logic [1:0] OSS_RESET = 2'd1;

endpackage

`default_nettype wire

// File: src/barometric_pressure_compensation_top.sv
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_top
// Integer compensation of raw temperature and pressure readings from a
// barometric sensor, using factory calibration words held in registers.
// ----------------------------------------------------------------------------
// The block takes one beat per cycle while out_stall is low and returns one
// beat per input beat, in order. It holds 4 front stages, a 27-stage
// temperature divider, 11 middle stages, a 64-stage pressure divider and 4
// back stages including the output register. The two dividers produce one
// quotient bit per stage; throughput stays one beat per cycle while the output
// is not stalled. Any empty stage lets the pipe close up, so input is taken
// while a finished result still waits at the output. Calibration and
// oversampling registers are read live by the stages that use them, so write
// them only while the pipe is empty. A zero divisor in either division raises
// divide_fault and forces both results to zero. The configuration port never
// stalls; writes to unknown indices are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module barometric_pressure_compensation_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // input beat
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [15:0]                  raw_temperature,
    input  wire logic [23:0]                  raw_pressure,
    // result beat
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic signed [15:0]                temperature_tenths,
    output logic signed [31:0]                pressure_pa,
    output logic                              divide_fault,
    // configuration writes
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                  cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0]  oss_reg;
    logic [31:0] cal_ac12_reg;
    logic [31:0] cal_ac34_reg;
    logic [31:0] cal_ac56_reg;
    logic [31:0] cal_b12_reg;
    logic [31:0] cal_mcmd_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oss_reg      <= bpc_pkg::OSS_RESET;
            cal_ac12_reg <= '0;
            cal_ac34_reg <= '0;
            cal_ac56_reg <= '0;
            cal_b12_reg  <= '0;
            cal_mcmd_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                bpc_pkg::REG_OVERSAMPLING: oss_reg      <= cfg_data[1:0];
                bpc_pkg::REG_AC1_AC2:      cal_ac12_reg <= cfg_data;
                bpc_pkg::REG_AC3_AC4:      cal_ac34_reg <= cfg_data;
                bpc_pkg::REG_AC5_AC6:      cal_ac56_reg <= cfg_data;
                bpc_pkg::REG_B1_B2:        cal_b12_reg  <= cfg_data;
                bpc_pkg::REG_MC_MD:        cal_mcmd_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Unpack calibration halves; AC4 and AC5 gain a zero sign bit, AC6 stays unsigned.
    logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic signed [16:0] ac4, ac5;
    logic        [15:0] ac6;

    assign ac1 = $signed(cal_ac12_reg[31:16]);
    assign ac2 = $signed(cal_ac12_reg[15:0]);
    assign ac3 = $signed(cal_ac34_reg[31:16]);
    assign ac4 = $signed({1'b0, cal_ac34_reg[15:0]});
    assign ac5 = $signed({1'b0, cal_ac56_reg[31:16]});
    assign ac6 = cal_ac56_reg[15:0];
    assign b1  = $signed(cal_b12_reg[31:16]);
    assign b2  = $signed(cal_b12_reg[15:0]);
    assign mc  = $signed(cal_mcmd_reg[31:16]);
    assign md  = $signed(cal_mcmd_reg[15:0]);

    // ------------------------------------------------------------------
    // Front stages: temperature term X1 and divider operands
    // ------------------------------------------------------------------
    logic [3:0] pre_v_reg;
    logic [4:0] pre_ld;
    logic       divt_in_ready;

    assign pre_ld[4] = divt_in_ready;
    for (genvar k = 0; k < 4; k++) begin : g_pre_ld
        assign pre_ld[k] = ~pre_v_reg[k] | pre_ld[k+1];
    end
    assign in_stall = ~pre_ld[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_v_reg <= '0;
        end
        else
        begin
            if (pre_ld[0]) pre_v_reg[0] <= in_valid;
            if (pre_ld[1]) pre_v_reg[1] <= pre_v_reg[0];
            if (pre_ld[2]) pre_v_reg[2] <= pre_v_reg[1];
            if (pre_ld[3]) pre_v_reg[3] <= pre_v_reg[2];
        end
    end

    // stage 0: UT - AC6, align raw pressure to UP
    logic signed [17:0] s0_diff_reg, s0_diff_next;
    logic        [18:0] s0_up_reg, s0_up_next;
    assign s0_diff_next = $signed({2'b00, raw_temperature}) - $signed({2'b00, ac6});
    assign s0_up_next   = 19'(raw_pressure >> (4'd8 - {2'b00, oss_reg}));

    // stage 1: (UT - AC6) * AC5
    logic signed [34:0] s1_prod_reg, s1_prod_next;
    logic        [18:0] s1_up_reg;
    assign s1_prod_next = 35'(s0_diff_reg) * 35'(ac5);

    // stage 2: X1 = prod / 2^15 toward zero, X1 + MD
    logic signed [34:0] s2_bias;
    logic signed [17:0] s2_x1_reg, s2_x1_next;
    logic signed [18:0] s2_dsum_reg, s2_dsum_next;
    logic        [18:0] s2_up_reg;
    assign s2_bias      = s1_prod_reg + (s1_prod_reg[34] ? 35'sd32767 : 35'sd0);
    assign s2_x1_next   = 18'(s2_bias >>> 15);
    assign s2_dsum_next = 19'(s2_x1_next) + 19'(md);

    // stage 3: magnitudes and sign for MC * 2048 / (X1 + MD)
    logic signed [26:0] s3_num_s;
    logic signed [18:0] s3_dneg;
    logic        [26:0] s3_na_reg, s3_na_next;
    logic        [17:0] s3_da_reg, s3_da_next;
    logic               s3_qneg_reg, s3_qneg_next;
    logic               s3_fault_reg, s3_fault_next;
    logic signed [17:0] s3_x1_reg;
    logic        [18:0] s3_up_reg;
    assign s3_num_s      = $signed({mc, 11'b0});
    assign s3_dneg       = -s2_dsum_reg;
    assign s3_na_next    = mc[15] ? 27'(-s3_num_s) : s3_num_s;
    assign s3_da_next    = s2_dsum_reg[18] ? s3_dneg[17:0] : s2_dsum_reg[17:0];
    assign s3_qneg_next  = mc[15] ^ s2_dsum_reg[18];
    assign s3_fault_next = (s2_dsum_reg == 19'sd0);

    always_ff @(posedge clk)
    begin
        if (pre_ld[0])
        begin
            s0_diff_reg <= s0_diff_next;
            s0_up_reg   <= s0_up_next;
        end
        if (pre_ld[1])
        begin
            s1_prod_reg <= s1_prod_next;
            s1_up_reg   <= s0_up_reg;
        end
        if (pre_ld[2])
        begin
            s2_x1_reg   <= s2_x1_next;
            s2_dsum_reg <= s2_dsum_next;
            s2_up_reg   <= s1_up_reg;
        end
        if (pre_ld[3])
        begin
            s3_na_reg    <= s3_na_next;
            s3_da_reg    <= s3_da_next;
            s3_qneg_reg  <= s3_qneg_next;
            s3_fault_reg <= s3_fault_next;
            s3_x1_reg    <= s2_x1_reg;
            s3_up_reg    <= s2_up_reg;
        end
    end

    // ------------------------------------------------------------------
    // Temperature divider: |MC * 2048| / |X1 + MD|
    // ------------------------------------------------------------------
    localparam int DT_PW = 18 + 1 + 1 + 19;

    logic              divt_out_valid;
    logic              divt_out_ready;
    logic [26:0]       divt_quo;
    logic [DT_PW-1:0]  divt_pay;

    bpc_div #(
        .NW (27),
        .DW (18),
        .PW (DT_PW)
    ) u_div_temp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pre_v_reg[3]),
        .in_ready  (divt_in_ready),
        .num       (s3_na_reg),
        .den       (s3_da_reg),
        .pay_in    ({s3_x1_reg, s3_qneg_reg, s3_fault_reg, s3_up_reg}),
        .out_valid (divt_out_valid),
        .out_ready (divt_out_ready),
        .quo       (divt_quo),
        .pay_out   (divt_pay)
    );

    logic signed [17:0] dt_x1;
    logic               dt_qneg;
    logic               dt_fault;
    logic        [18:0] dt_up;
    assign {dt_x1, dt_qneg, dt_fault, dt_up} = divt_pay;

    // ------------------------------------------------------------------
    // Middle stages: B5, B6, B3, B4, B7
    // ------------------------------------------------------------------
    logic [10:0] mid_v_reg;
    logic [11:0] mid_ld;
    logic        divp_in_ready;

    assign mid_ld[11] = divp_in_ready;
    for (genvar k = 0; k < 11; k++) begin : g_mid_ld
        assign mid_ld[k] = ~mid_v_reg[k] | mid_ld[k+1];
    end
    assign divt_out_ready = mid_ld[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_v_reg <= '0;
        end
        else
        begin
            if (mid_ld[0]) mid_v_reg[0] <= divt_out_valid;
            for (int k = 1; k < 11; k++)
            begin
                if (mid_ld[k]) mid_v_reg[k] <= mid_v_reg[k-1];
            end
        end
    end

    // m0: apply quotient sign, B5 = X1 + X2
    logic signed [27:0] m0_x2;
    logic signed [28:0] m0_b5_reg, m0_b5_next;
    logic               m0_fault_reg;
    logic        [18:0] m0_up_reg;
    assign m0_x2      = dt_qneg ? -$signed({1'b0, divt_quo}) : $signed({1'b0, divt_quo});
    assign m0_b5_next = 29'(dt_x1) + 29'(m0_x2);

    // m1: B6 and the saturated temperature
    logic signed [28:0] m1_tb, m1_tq;
    logic signed [28:0] m1_b6_reg, m1_b6_next;
    logic signed [15:0] m1_t_reg, m1_t_next;
    logic               m1_fault_reg;
    logic        [18:0] m1_up_reg;
    assign m1_b6_next = m0_b5_reg - 29'sd4000;
    assign m1_tb      = m0_b5_reg + 29'sd8;
    assign m1_tq      = (m1_tb + (m1_tb[28] ? 29'sd15 : 29'sd0)) >>> 4;
    always_comb
    begin
        if (m1_tq > 29'sd32767)
            m1_t_next = 16'sh7fff;
        else if (m1_tq < -29'sd32768)
            m1_t_next = 16'sh8000;
        else
            m1_t_next = 16'(m1_tq);
    end

    // m2: B6^2, AC2*B6, AC3*B6
    logic signed [57:0] m2_sqp_reg, m2_sqp_next;
    logic signed [44:0] m2_pac2_reg, m2_pac2_next;
    logic signed [44:0] m2_pac3_reg, m2_pac3_next;
    logic signed [15:0] m2_t_reg;
    logic               m2_fault_reg;
    logic        [18:0] m2_up_reg;
    assign m2_sqp_next  = 58'(m1_b6_reg) * 58'(m1_b6_reg);
    assign m2_pac2_next = 45'(m1_b6_reg) * 45'(ac2);
    assign m2_pac3_next = 45'(m1_b6_reg) * 45'(ac3);

    // m3: scale down toward zero
    logic signed [44:0] m3_b2a, m3_b3a;
    logic signed [45:0] m3_sq_reg, m3_sq_next;
    logic signed [33:0] m3_x2a_reg, m3_x2a_next;
    logic signed [31:0] m3_x1c_reg, m3_x1c_next;
    logic signed [15:0] m3_t_reg;
    logic               m3_fault_reg;
    logic        [18:0] m3_up_reg;
    assign m3_sq_next  = 46'(m2_sqp_reg >>> 12);
    assign m3_b2a      = m2_pac2_reg + (m2_pac2_reg[44] ? 45'sd2047 : 45'sd0);
    assign m3_x2a_next = 34'(m3_b2a >>> 11);
    assign m3_b3a      = m2_pac3_reg + (m2_pac3_reg[44] ? 45'sd8191 : 45'sd0);
    assign m3_x1c_next = 32'(m3_b3a >>> 13);

    // m4: B2*SQ, B1*SQ
    logic signed [61:0] m4_pb2_reg, m4_pb2_next;
    logic signed [61:0] m4_pb1_reg, m4_pb1_next;
    logic signed [33:0] m4_x2a_reg;
    logic signed [31:0] m4_x1c_reg;
    logic signed [15:0] m4_t_reg;
    logic               m4_fault_reg;
    logic        [18:0] m4_up_reg;
    assign m4_pb2_next = 62'(m3_sq_reg) * 62'(b2);
    assign m4_pb1_next = 62'(m3_sq_reg) * 62'(b1);

    // m5: X3 for B3 and partial sum for B4
    logic signed [61:0] m5_b2a, m5_b1a;
    logic signed [50:0] m5_x1a;
    logic signed [45:0] m5_x2c;
    logic signed [51:0] m5_x3a_reg, m5_x3a_next;
    logic signed [46:0] m5_sc_reg, m5_sc_next;
    logic signed [15:0] m5_t_reg;
    logic               m5_fault_reg;
    logic        [18:0] m5_up_reg;
    assign m5_b2a      = m4_pb2_reg + (m4_pb2_reg[61] ? 62'sd2047 : 62'sd0);
    assign m5_x1a      = 51'(m5_b2a >>> 11);
    assign m5_x3a_next = 52'(m5_x1a) + 52'(m4_x2a_reg);
    assign m5_b1a      = m4_pb1_reg + (m4_pb1_reg[61] ? 62'sd65535 : 62'sd0);
    assign m5_x2c      = 46'(m5_b1a >>> 16);
    assign m5_sc_next  = 47'(m4_x1c_reg) + 47'(m5_x2c);

    // m6: B3 numerator, X3 for B4
    logic signed [56:0] m6_sum;
    logic signed [47:0] m6_sc2;
    logic signed [56:0] m6_b3n_reg, m6_b3n_next;
    logic signed [45:0] m6_x3c_reg, m6_x3c_next;
    logic signed [15:0] m6_t_reg;
    logic               m6_fault_reg;
    logic        [18:0] m6_up_reg;
    assign m6_sum      = (57'(ac1) <<< 2) + 57'(m5_x3a_reg);
    assign m6_b3n_next = (m6_sum <<< oss_reg) + 57'sd2;
    assign m6_sc2      = 48'(m5_sc_reg) + 48'sd2;
    assign m6_x3c_next = 46'((m6_sc2 + (m6_sc2[47] ? 48'sd3 : 48'sd0)) >>> 2);

    // m7: B3, AC4 * (X3 + 32768) kept modulo 2^64
    logic signed [56:0] m7_b3b;
    logic signed [54:0] m7_b3_reg, m7_b3_next;
    logic signed [63:0] m7_b4p_reg, m7_b4p_next;
    logic signed [15:0] m7_t_reg;
    logic               m7_fault_reg;
    logic        [18:0] m7_up_reg;
    assign m7_b3b      = m6_b3n_reg + (m6_b3n_reg[56] ? 57'sd3 : 57'sd0);
    assign m7_b3_next  = 55'(m7_b3b >>> 2);
    assign m7_b4p_next = 64'(ac4) * (64'(m6_x3c_reg) + 64'sd32768);

    // m8: B4 as unsigned shift, UP - B3 modulo 2^64
    logic        [48:0] m8_b4_reg, m8_b4_next;
    logic        [63:0] m8_diff_reg, m8_diff_next;
    logic signed [15:0] m8_t_reg;
    logic               m8_fault_reg, m8_fault_next;
    assign m8_b4_next    = m7_b4p_reg[63:15];
    assign m8_diff_next  = {45'b0, m7_up_reg} - {{9{m7_b3_reg[54]}}, m7_b3_reg};
    assign m8_fault_next = m7_fault_reg | (m8_b4_next == 49'd0);

    // m9: B7 = (UP - B3) * (50000 >> OSS) modulo 2^64
    logic        [15:0] m9_k;
    logic        [63:0] m9_b7_reg, m9_b7_next;
    logic        [48:0] m9_b4_reg;
    logic signed [15:0] m9_t_reg;
    logic               m9_fault_reg;
    assign m9_k       = 16'(17'd50000 >> oss_reg);
    assign m9_b7_next = m8_diff_reg * {48'b0, m9_k};

    // m10: pick the dividend so one division covers both datasheet forms
    logic               m10_small_reg, m10_small_next;
    logic        [63:0] m10_num_reg, m10_num_next;
    logic        [48:0] m10_b4_reg;
    logic signed [15:0] m10_t_reg;
    logic               m10_fault_reg;
    assign m10_small_next = (m9_b7_reg < 64'h8000_0000);
    assign m10_num_next   = m10_small_next ? {m9_b7_reg[62:0], 1'b0} : m9_b7_reg;

    always_ff @(posedge clk)
    begin
        if (mid_ld[0])
        begin
            m0_b5_reg    <= m0_b5_next;
            m0_fault_reg <= dt_fault;
            m0_up_reg    <= dt_up;
        end
        if (mid_ld[1])
        begin
            m1_b6_reg    <= m1_b6_next;
            m1_t_reg     <= m1_t_next;
            m1_fault_reg <= m0_fault_reg;
            m1_up_reg    <= m0_up_reg;
        end
        if (mid_ld[2])
        begin
            m2_sqp_reg   <= m2_sqp_next;
            m2_pac2_reg  <= m2_pac2_next;
            m2_pac3_reg  <= m2_pac3_next;
            m2_t_reg     <= m1_t_reg;
            m2_fault_reg <= m1_fault_reg;
            m2_up_reg    <= m1_up_reg;
        end
        if (mid_ld[3])
        begin
            m3_sq_reg    <= m3_sq_next;
            m3_x2a_reg   <= m3_x2a_next;
            m3_x1c_reg   <= m3_x1c_next;
            m3_t_reg     <= m2_t_reg;
            m3_fault_reg <= m2_fault_reg;
            m3_up_reg    <= m2_up_reg;
        end
        if (mid_ld[4])
        begin
            m4_pb2_reg   <= m4_pb2_next;
            m4_pb1_reg   <= m4_pb1_next;
            m4_x2a_reg   <= m3_x2a_reg;
            m4_x1c_reg   <= m3_x1c_reg;
            m4_t_reg     <= m3_t_reg;
            m4_fault_reg <= m3_fault_reg;
            m4_up_reg    <= m3_up_reg;
        end
        if (mid_ld[5])
        begin
            m5_x3a_reg   <= m5_x3a_next;
            m5_sc_reg    <= m5_sc_next;
            m5_t_reg     <= m4_t_reg;
            m5_fault_reg <= m4_fault_reg;
            m5_up_reg    <= m4_up_reg;
        end
        if (mid_ld[6])
        begin
            m6_b3n_reg   <= m6_b3n_next;
            m6_x3c_reg   <= m6_x3c_next;
            m6_t_reg     <= m5_t_reg;
            m6_fault_reg <= m5_fault_reg;
            m6_up_reg    <= m5_up_reg;
        end
        if (mid_ld[7])
        begin
            m7_b3_reg    <= m7_b3_next;
            m7_b4p_reg   <= m7_b4p_next;
            m7_t_reg     <= m6_t_reg;
            m7_fault_reg <= m6_fault_reg;
            m7_up_reg    <= m6_up_reg;
        end
        if (mid_ld[8])
        begin
            m8_b4_reg    <= m8_b4_next;
            m8_diff_reg  <= m8_diff_next;
            m8_t_reg     <= m7_t_reg;
            m8_fault_reg <= m8_fault_next;
        end
        if (mid_ld[9])
        begin
            m9_b7_reg    <= m9_b7_next;
            m9_b4_reg    <= m8_b4_reg;
            m9_t_reg     <= m8_t_reg;
            m9_fault_reg <= m8_fault_reg;
        end
        if (mid_ld[10])
        begin
            m10_small_reg <= m10_small_next;
            m10_num_reg   <= m10_num_next;
            m10_b4_reg    <= m9_b4_reg;
            m10_t_reg     <= m9_t_reg;
            m10_fault_reg <= m9_fault_reg;
        end
    end

    // ------------------------------------------------------------------
    // Pressure divider: B7 (or 2*B7) / B4
    // ------------------------------------------------------------------
    localparam int DP_PW = 1 + 16 + 1;

    logic              divp_out_valid;
    logic              divp_out_ready;
    logic [63:0]       divp_quo;
    logic [DP_PW-1:0]  divp_pay;

    bpc_div #(
        .NW (64),
        .DW (49),
        .PW (DP_PW)
    ) u_div_pres (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_v_reg[10]),
        .in_ready  (divp_in_ready),
        .num       (m10_num_reg),
        .den       (m10_b4_reg),
        .pay_in    ({m10_small_reg, m10_t_reg, m10_fault_reg}),
        .out_valid (divp_out_valid),
        .out_ready (divp_out_ready),
        .quo       (divp_quo),
        .pay_out   (divp_pay)
    );

    logic               dp_small;
    logic signed [15:0] dp_t;
    logic               dp_fault;
    assign {dp_small, dp_t, dp_fault} = divp_pay;

    // ------------------------------------------------------------------
    // Back stages: second-order pressure correction and output register
    // ------------------------------------------------------------------
    logic [3:0] post_v_reg;
    logic [4:0] post_ld;

    // output register frees when empty or when the beat is taken
    assign post_ld[4] = ~out_stall;
    for (genvar k = 0; k < 4; k++) begin : g_post_ld
        assign post_ld[k] = ~post_v_reg[k] | post_ld[k+1];
    end
    assign divp_out_ready = post_ld[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            post_v_reg <= '0;
        end
        else
        begin
            if (post_ld[0]) post_v_reg[0] <= divp_out_valid;
            if (post_ld[1]) post_v_reg[1] <= post_v_reg[0];
            if (post_ld[2]) post_v_reg[2] <= post_v_reg[1];
            if (post_ld[3]) post_v_reg[3] <= post_v_reg[2];
        end
    end

    // p0: first pressure estimate, low 32 bits
    logic        [31:0] p0_pu;
    logic signed [31:0] p0_p_reg, p0_p_next;
    logic signed [15:0] p0_t_reg;
    logic               p0_fault_reg;
    assign p0_pu     = dp_small ? divp_quo[31:0] : {divp_quo[30:0], 1'b0};
    assign p0_p_next = $signed(p0_pu);

    // p1: (p/256)^2 and -7357*p
    logic signed [32:0] p1_pb;
    logic signed [23:0] p1_pp;
    logic signed [47:0] p1_pp2_reg, p1_pp2_next;
    logic signed [45:0] p1_m_reg, p1_m_next;
    logic signed [31:0] p1_p_reg;
    logic signed [15:0] p1_t_reg;
    logic               p1_fault_reg;
    assign p1_pb       = 33'(p0_p_reg) + (p0_p_reg[31] ? 33'sd255 : 33'sd0);
    assign p1_pp       = 24'(p1_pb >>> 8);
    assign p1_pp2_next = 48'(p1_pp) * 48'(p1_pp);
    assign p1_m_next   = 46'(p0_p_reg) * -46'sd7357;

    // p2: scale the square by 3038, X2 toward zero
    logic signed [45:0] p2_mb;
    logic signed [59:0] p2_x1m_reg, p2_x1m_next;
    logic signed [29:0] p2_x2_reg, p2_x2_next;
    logic signed [31:0] p2_p_reg;
    logic signed [15:0] p2_t_reg;
    logic               p2_fault_reg;
    assign p2_x1m_next = 60'(p1_pp2_reg) * 60'sd3038;
    assign p2_mb       = p1_m_reg + (p1_m_reg[45] ? 46'sd65535 : 46'sd0);
    assign p2_x2_next  = 30'(p2_mb >>> 16);

    // p3: final sum into the output register; zero both results on a fault
    logic signed [43:0] p3_x1;
    logic signed [45:0] p3_s;
    logic signed [41:0] p3_c;
    logic signed [31:0] p3_p2;
    logic signed [15:0] temp_reg, temp_next;
    logic signed [31:0] pres_reg, pres_next;
    logic               fault_reg;
    assign p3_x1     = 44'(p2_x1m_reg >>> 16);
    assign p3_s      = 46'(p3_x1) + 46'(p2_x2_reg) + 46'sd3791;
    assign p3_c      = 42'((p3_s + (p3_s[45] ? 46'sd15 : 46'sd0)) >>> 4);
    assign p3_p2     = p2_p_reg + 32'(p3_c);
    assign temp_next = p2_fault_reg ? 16'sd0 : p2_t_reg;
    assign pres_next = p2_fault_reg ? 32'sd0 : p3_p2;

    always_ff @(posedge clk)
    begin
        if (post_ld[0])
        begin
            p0_p_reg     <= p0_p_next;
            p0_t_reg     <= dp_t;
            p0_fault_reg <= dp_fault;
        end
        if (post_ld[1])
        begin
            p1_pp2_reg   <= p1_pp2_next;
            p1_m_reg     <= p1_m_next;
            p1_p_reg     <= p0_p_reg;
            p1_t_reg     <= p0_t_reg;
            p1_fault_reg <= p0_fault_reg;
        end
        if (post_ld[2])
        begin
            p2_x1m_reg   <= p2_x1m_next;
            p2_x2_reg    <= p2_x2_next;
            p2_p_reg     <= p1_p_reg;
            p2_t_reg     <= p1_t_reg;
            p2_fault_reg <= p1_fault_reg;
        end
        if (post_ld[3])
        begin
            temp_reg  <= temp_next;
            pres_reg  <= pres_next;
            fault_reg <= p2_fault_reg;
        end
    end

    assign out_valid          = post_v_reg[3];
    assign temperature_tenths = temp_reg;
    assign pressure_pa        = pres_reg;
    assign divide_fault       = fault_reg;

endmodule

`default_nettype wire

// File: src/bpc_div.sv
// ----------------------------------------------------------------------------
// bpc_div
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// side payload that travels alongside each beat.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_div #(
    parameter int NW = 64,
    parameter int DW = 49,
    parameter int PW = 18
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    input  wire logic [PW-1:0] pay_in,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [NW-1:0]      quo,
    output logic [PW-1:0]      pay_out
);

    logic [NW-1:0] v_reg;
    logic [NW:0]   ld;
    logic [NW-1:0] word_reg [NW];
    logic [DW-1:0] rem_reg  [NW];
    logic [DW-1:0] den_reg  [NW];
    logic [PW-1:0] pay_reg  [NW];

    assign ld[NW] = out_ready;

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic          vin;
        logic [NW-1:0] win;
        logic [DW-1:0] rin;
        logic [DW-1:0] din;
        logic [PW-1:0] pin;
        logic [DW:0]   trial;
        logic          qbit;
        logic [DW-1:0] rem_next;
        logic [NW-1:0] word_next;

        if (k == 0) begin : g_first
            assign vin = in_valid;
            assign win = num;
            assign rin = '0;
            assign din = den;
            assign pin = pay_in;
        end else begin : g_rest
            assign vin = v_reg[k-1];
            assign win = word_reg[k-1];
            assign rin = rem_reg[k-1];
            assign din = den_reg[k-1];
            assign pin = pay_reg[k-1];
        end

        assign ld[k]     = ~v_reg[k] | ld[k+1];
        // trial subtract of the divisor from the shifted partial remainder
        assign trial     = {rin, win[NW-1]} - {1'b0, din};
        assign qbit      = ~trial[DW];
        assign rem_next  = qbit ? trial[DW-1:0] : {rin[DW-2:0], win[NW-1]};
        assign word_next = {win[NW-2:0], qbit};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (ld[k])
            begin
                v_reg[k] <= vin;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ld[k])
            begin
                word_reg[k] <= word_next;
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= din;
                pay_reg[k]  <= pin;
            end
        end
    end

    assign in_ready  = ld[0];
    assign out_valid = v_reg[NW-1];
    assign quo       = word_reg[NW-1];
    assign pay_out   = pay_reg[NW-1];

endmodule

`default_nettype wire

// File: src/bpc_checker.sv
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level checks for the barometric pressure compensation block, bound to
// the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic [15:0]                   raw_temperature,
    input wire logic [23:0]                   raw_pressure,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic signed [15:0]            temperature_tenths,
    input wire logic signed [31:0]            pressure_pa,
    input wire logic                          divide_fault,
    input wire logic                          cfg_valid,
    input wire logic                          cfg_ready
);

    // a stalled input beat holds until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(raw_temperature)
            && $stable(raw_pressure))
        else $error("input beat changed while stalled");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(temperature_tenths)
            && $stable(pressure_pa) && $stable(divide_fault))
        else $error("result beat changed while stalled");

    // a faulted beat carries zero results
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_fault |-> temperature_tenths == 16'sd0
            && pressure_pa == 32'sd0)
        else $error("fault beat with non-zero results");

    // an empty output register lets the pipe close up, so input is never held
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    // configuration writes are never held off
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write held off");

endmodule

bind barometric_pressure_compensation_top bpc_checker u_bpc_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .raw_temperature    (raw_temperature),
    .raw_pressure       (raw_pressure),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .temperature_tenths (temperature_tenths),
    .pressure_pa        (pressure_pa),
    .divide_fault       (divide_fault),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready)
);

`default_nettype wire
